[src/lrupr_pkg.sv]
// Shared types and constants for the LRU page replacement block.
package lrupr_pkg;

  localparam int CFG_W         = 5;
  localparam int PAGE_REF_W    = 16;
  localparam int FRAME_FIELD_W = 4;
  localparam int EVICT_PAGE_W  = 16;
  localparam int FAULT_W       = 32;
  localparam int AGE_W         = 16;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd4;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;

  // tuser bit positions on the result side
  localparam int TUSER_HIT     = 0;
  localparam int TUSER_EVICTED = 1;

  // tdata bit positions on the result side
  localparam int TD_FRAME_LSB = 0;
  localparam int TD_EPAGE_LSB = TD_FRAME_LSB + FRAME_FIELD_W;
  localparam int TD_FAULT_LSB = TD_EPAGE_LSB + EVICT_PAGE_W;
  localparam int TD_USED_W    = TD_FAULT_LSB + FAULT_W;

  typedef struct packed {
    logic start;   // latch the reference and restart the scan
    logic scan;    // issue frame reads and age resident frames
    logic commit;  // place the page, update count, load the result
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

[src/lru_page_replacement.sv]
// Top level of the LRU page replacement block with per-frame age counters.
//
// Each page reference arriving on the slave stream is looked up in a table of
// frames_in_use frames (clamped to 1..MAX_FRAMES). The first resident frame
// holding the page is a hit; otherwise the first empty frame is filled, or,
// with the table full, the frame with the greatest age is evicted (lowest
// index on ties), and a saturating fault count advances. The frame used gets
// age 1 and every other resident frame ages by one, saturating. A reference
// marked by tlast returns its result and then clears the table and the fault
// count. Each item goes through an accept, a scan over the clamped number of frames
// through the single read port of the frame page and age memories (aging is
// written back during the same pass), and a commit that writes the chosen
// frame and loads the result register. The next reference is accepted while a
// result still waits in the result register; commit waits only if that
// register is still full. Configuration writes are always ready and take
// effect for the next accepted reference.
module lru_page_replacement #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: frames_in_use
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lrupr_pkg::CFG_W-1:0]       cfg_data_i,
  // page references
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lrupr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] page_ref
  input  logic                              s_axis_tlast,  // end_of_string
  // results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lrupr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [3:0] frame_used, [19:4] evicted_page, [51:20] fault_total, [55:52] zero
  output logic [lrupr_pkg::OUT_TUSER_W-1:0] m_axis_tuser   // [0] hit, [1] evicted
);

  lrupr_pkg::cmd_t cmd;
  lrupr_pkg::sts_t sts;

  logic                                out_hit;
  logic [lrupr_pkg::FRAME_FIELD_W-1:0] out_frame;
  logic                                out_evicted;
  logic [lrupr_pkg::EVICT_PAGE_W-1:0]  out_epage;
  logic [lrupr_pkg::FAULT_W-1:0]       out_fault;

  // the register is a plain flop: every write transaction lands at once
  assign cfg_ready_o = 1'b1;

  lrupr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrupr_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .page_ref_i    (s_axis_tdata[lrupr_pkg::PAGE_REF_W-1:0]),
    .eos_i         (s_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_hit_o     (out_hit),
    .out_frame_o   (out_frame),
    .out_evicted_o (out_evicted),
    .out_epage_o   (out_epage),
    .out_fault_o   (out_fault)
  );

  // pack the result transaction, lowest field first
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[lrupr_pkg::TD_FRAME_LSB +: lrupr_pkg::FRAME_FIELD_W] = out_frame;
    m_axis_tdata[lrupr_pkg::TD_EPAGE_LSB +: lrupr_pkg::EVICT_PAGE_W]  = out_epage;
    m_axis_tdata[lrupr_pkg::TD_FAULT_LSB +: lrupr_pkg::FAULT_W]       = out_fault;
    m_axis_tuser = '0;
    m_axis_tuser[lrupr_pkg::TUSER_HIT]     = out_hit;
    m_axis_tuser[lrupr_pkg::TUSER_EVICTED] = out_evicted;
  end

endmodule

[src/lrupr_ctrl.sv]
// Sequencing state machine for the LRU page replacement block.
module lrupr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lrupr_pkg::sts_t sts_i,
  output lrupr_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_WAIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.out_free) begin
            cmd_o.commit = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        // hold until the result register drains
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/lrupr_dp.sv]
// Frame table, scan datapath, fault counter and result register.
module lrupr_dp #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lrupr_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [lrupr_pkg::PAGE_REF_W-1:0]    page_ref_i,
  input  logic                                eos_i,
  input  lrupr_pkg::cmd_t                     cmd_i,
  output lrupr_pkg::sts_t                     sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_hit_o,
  output logic [lrupr_pkg::FRAME_FIELD_W-1:0] out_frame_o,
  output logic                                out_evicted_o,
  output logic [lrupr_pkg::EVICT_PAGE_W-1:0]  out_epage_o,
  output logic [lrupr_pkg::FAULT_W-1:0]       out_fault_o
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int AW = lrupr_pkg::AGE_W;
  localparam int FW = lrupr_pkg::FAULT_W;

  logic [lrupr_pkg::CFG_W-1:0] frames_q;
  logic [CW-1:0]               n_q;
  logic [PAGE_BITS-1:0]        page_q;
  logic                        eos_q;

  logic [PAGE_BITS-1:0] page_mem [MAX_FRAMES];
  logic [AW-1:0]        age_mem  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q;

  logic [PAGE_BITS-1:0] page_rd_q;
  logic [AW-1:0]        age_rd_q;
  logic [CW-1:0]        rd_cnt_q;
  logic                 proc_vld_q;
  logic [IW-1:0]        proc_idx_q;
  logic                 issue;
  logic [IW-1:0]        rd_addr;

  logic                 hit_fnd_q, empty_fnd_q;
  logic [IW-1:0]        hit_idx_q, empty_idx_q, old_idx_q;
  logic [AW-1:0]        best_age_q;
  logic [PAGE_BITS-1:0] old_page_q;

  logic [FW-1:0]        fault_q;
  logic [FW-1:0]        fault_inc;
  logic [IW-1:0]        chosen;
  logic                 cur_valid;

  // frame count clamp: zero acts as one, large values act as MAX_FRAMES
  logic [CW-1:0] n_clamped;
  always_comb begin
    if (frames_q == '0) begin
      n_clamped = CW'(1);
    end else if (int'(frames_q) > MAX_FRAMES) begin
      n_clamped = CW'(MAX_FRAMES);
    end else begin
      n_clamped = CW'(frames_q);
    end
  end

  assign issue     = cmd_i.scan && (rd_cnt_q < n_q);
  assign rd_addr   = rd_cnt_q[IW-1:0];
  assign cur_valid = valid_q[proc_idx_q];

  assign sts_o.scan_done = (rd_cnt_q == n_q) && !proc_vld_q;
  assign sts_o.out_free  = !out_valid_o || out_ready_i;

  always_comb begin
    if (hit_fnd_q) begin
      chosen = hit_idx_q;
    end else if (empty_fnd_q) begin
      chosen = empty_idx_q;
    end else begin
      chosen = old_idx_q;
    end
  end

  assign fault_inc = (hit_fnd_q || fault_q == '1) ? fault_q : fault_q + FW'(1);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= lrupr_pkg::FRAMES_RESET;
    end else if (cfg_we_i) begin
      frames_q <= cfg_data_i;
    end
  end

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      page_q <= PAGE_BITS'(page_ref_i);
      eos_q  <= eos_i;
      n_q    <= n_clamped;
    end
  end

  // frame table memories: one read and one write per cycle
  always_ff @(posedge clk_i) begin
    page_rd_q <= page_mem[rd_addr];
    age_rd_q  <= age_mem[rd_addr];
    if (cmd_i.commit) begin
      page_mem[chosen] <= page_q;
    end
    if (cmd_i.commit) begin
      age_mem[chosen] <= AW'(1);
    end else if (proc_vld_q && cur_valid && age_rd_q != '1) begin
      age_mem[proc_idx_q] <= age_rd_q + AW'(1);
    end
  end

  // scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q   <= '0;
      proc_vld_q <= 1'b0;
      proc_idx_q <= '0;
    end else begin
      if (cmd_i.start) begin
        rd_cnt_q <= '0;
      end else if (issue) begin
        rd_cnt_q <= rd_cnt_q + CW'(1);
      end
      proc_vld_q <= issue;
      proc_idx_q <= rd_addr;
    end
  end

  // hit, empty and oldest search over the returning reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hit_fnd_q   <= 1'b0;
      empty_fnd_q <= 1'b0;
    end else if (proc_vld_q) begin
      if (cur_valid && page_rd_q == page_q && !hit_fnd_q) begin
        hit_fnd_q <= 1'b1;
        hit_idx_q <= proc_idx_q;
      end
      if (!cur_valid && !empty_fnd_q) begin
        empty_fnd_q <= 1'b1;
        empty_idx_q <= proc_idx_q;
      end
      if (proc_idx_q == '0 || age_rd_q > best_age_q) begin
        best_age_q <= age_rd_q;
        old_idx_q  <= proc_idx_q;
        old_page_q <= page_rd_q;
      end
    end
  end

  // valid bits and fault counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fault_q <= '0;
    end else if (cmd_i.commit) begin
      if (eos_q) begin
        valid_q <= '0;
        fault_q <= '0;
      end else begin
        valid_q[chosen] <= 1'b1;
        fault_q         <= fault_inc;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_hit_o     <= hit_fnd_q;
      out_frame_o   <= lrupr_pkg::FRAME_FIELD_W'(chosen);
      out_evicted_o <= !hit_fnd_q && !empty_fnd_q;
      out_epage_o   <= (!hit_fnd_q && !empty_fnd_q) ?
                       lrupr_pkg::EVICT_PAGE_W'(old_page_q) : '0;
      out_fault_o   <= fault_inc;
    end
  end

endmodule

[src/lrupr_chk.sv]
// Port-level checker for the LRU page replacement block, with its bind.
module lrupr_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [lrupr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [lrupr_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result payload changed while stalled");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[lrupr_pkg::TUSER_HIT] &&
                        m_axis_tuser[lrupr_pkg::TUSER_EVICTED]))
    else $error("hit and eviction flagged together");

  // evicted page reads zero unless a page was evicted
  a_epage_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[lrupr_pkg::TUSER_EVICTED]) |->
      (m_axis_tdata[lrupr_pkg::TD_EPAGE_LSB +: lrupr_pkg::EVICT_PAGE_W] == '0))
    else $error("evicted page nonzero without eviction");

  // one reference at a time: the scan keeps the input closed after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input reopened right after a transaction");

endmodule

bind lru_page_replacement lrupr_chk u_lrupr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/lrupr_checker.sv]
// Checker for the LRU page replacement block: predicts each result and compares it.
module lrupr_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [lrupr_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                              ref_valid_i,
  input  logic                              ref_ready_i,
  input  logic [lrupr_pkg::IN_TDATA_W-1:0]  ref_page_i,
  input  logic                              ref_last_i,
  input  logic                              res_valid_i,
  input  logic                              res_ready_i,
  input  logic [lrupr_pkg::OUT_TDATA_W-1:0] res_data_i,
  input  logic [lrupr_pkg::OUT_TUSER_W-1:0] res_user_i,
  output int unsigned                       mismatches_o,
  output int unsigned                       outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_SLOTS = 16;
  localparam int FRAME_W     = lrupr_pkg::FRAME_FIELD_W;
  localparam int AGE_BITS    = lrupr_pkg::AGE_W;
  localparam int EPAGE_W     = lrupr_pkg::EVICT_PAGE_W;
  localparam int FAULT_BITS  = lrupr_pkg::FAULT_W;
  localparam int PAGE_W      = lrupr_pkg::PAGE_REF_W;

  typedef struct packed {
    logic                  hit;
    logic [FRAME_W-1:0]    frame_used;
    logic                  evicted;
    logic [EPAGE_W-1:0]    evicted_page;
    logic [FAULT_BITS-1:0] fault_total;
  } page_outcome_t;

  logic [lrupr_pkg::CFG_W-1:0] frames_cfg = lrupr_pkg::FRAMES_RESET;
  logic                  resident  [FRAME_SLOTS];
  logic [PAGE_W-1:0]     held_page [FRAME_SLOTS];
  logic [AGE_BITS-1:0]   frame_age [FRAME_SLOTS];
  logic [FAULT_BITS-1:0] fault_count;
  page_outcome_t         pending_outcomes[$];
  int unsigned           results_seen;

  function automatic void clear_table();
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      resident[i]  = 1'b0;
      held_page[i] = '0;
      frame_age[i] = '0;
    end
    fault_count = '0;
  endfunction

  // Look the page up, pick the frame, age the rest and build the result.
  function automatic page_outcome_t predict_reference(input logic [PAGE_W-1:0] pg,
                                                      input logic eos);
    int            n;
    int            hit_at;
    int            empty_at;
    int            pick;
    logic [AGE_BITS-1:0] oldest;
    page_outcome_t res;
    if (frames_cfg == '0) n = 1;
    else if (int'(frames_cfg) > FRAME_SLOTS) n = FRAME_SLOTS;
    else n = int'(frames_cfg);
    hit_at   = -1;
    empty_at = -1;
    res      = '0;
    for (int i = 0; i < n; i++) begin
      if (resident[i] && held_page[i] == pg && hit_at < 0) hit_at = i;
      if (!resident[i] && empty_at < 0) empty_at = i;
    end
    if (hit_at >= 0) begin
      pick    = hit_at;
      res.hit = 1'b1;
    end else begin
      if (empty_at >= 0) begin
        pick = empty_at;
      end else begin
        // victim is chosen on the ages held before this reference ages anything
        pick   = 0;
        oldest = frame_age[0];
        for (int i = 1; i < n; i++) begin
          if (frame_age[i] > oldest) begin
            oldest = frame_age[i];
            pick   = i;
          end
        end
        res.evicted      = 1'b1;
        res.evicted_page = held_page[pick];
      end
      if (fault_count != '1) fault_count++;
    end
    for (int i = 0; i < n; i++) begin
      if (i != pick && resident[i] && frame_age[i] != '1) frame_age[i]++;
    end
    resident[pick]  = 1'b1;
    held_page[pick] = pg;
    frame_age[pick] = AGE_BITS'(1);
    res.frame_used  = FRAME_W'(pick);
    res.fault_total = fault_count;
    if (eos) clear_table();
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t lrupr_checker: result %0d %s: got 0x%0h, want 0x%0h",
             $realtime, results_seen, what, got, want);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    page_outcome_t want;
    if (!rst_ni) begin
      clear_table();
      frames_cfg = lrupr_pkg::FRAMES_RESET;
      pending_outcomes.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
      results_seen  = 0;
    end else begin
      // compare first: a result can never belong to a reference taken this edge
      if (res_valid_i && res_ready_i) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("arrived with nothing expected", 64'(res_data_i), 64'd0);
        end else begin
          want = pending_outcomes.pop_front();
          if (res_user_i[lrupr_pkg::TUSER_HIT] !== want.hit)
            report_mismatch("hit", 64'(res_user_i[lrupr_pkg::TUSER_HIT]), 64'(want.hit));
          if (res_data_i[lrupr_pkg::TD_FRAME_LSB +: FRAME_W] !== want.frame_used)
            report_mismatch("frame_used",
                            64'(res_data_i[lrupr_pkg::TD_FRAME_LSB +: FRAME_W]),
                            64'(want.frame_used));
          if (res_user_i[lrupr_pkg::TUSER_EVICTED] !== want.evicted)
            report_mismatch("evicted", 64'(res_user_i[lrupr_pkg::TUSER_EVICTED]),
                            64'(want.evicted));
          if (res_data_i[lrupr_pkg::TD_EPAGE_LSB +: EPAGE_W] !== want.evicted_page)
            report_mismatch("evicted_page",
                            64'(res_data_i[lrupr_pkg::TD_EPAGE_LSB +: EPAGE_W]),
                            64'(want.evicted_page));
          if (res_data_i[lrupr_pkg::TD_FAULT_LSB +: FAULT_BITS] !== want.fault_total)
            report_mismatch("fault_total",
                            64'(res_data_i[lrupr_pkg::TD_FAULT_LSB +: FAULT_BITS]),
                            64'(want.fault_total));
          if (res_data_i[lrupr_pkg::OUT_TDATA_W-1:lrupr_pkg::TD_USED_W] !== '0)
            report_mismatch("padding",
                            64'(res_data_i[lrupr_pkg::OUT_TDATA_W-1:lrupr_pkg::TD_USED_W]),
                            64'd0);
        end
        results_seen++;
      end
      if (ref_valid_i && ref_ready_i)
        pending_outcomes.push_back(predict_reference(ref_page_i, ref_last_i));
      if (cfg_valid_i && cfg_ready_i) frames_cfg = cfg_data_i;
      outstanding_o = pending_outcomes.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top for the LRU page replacement block: stimulus, stalls and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFG_BITS        = lrupr_pkg::CFG_W;
  localparam int PAGE_W          = lrupr_pkg::PAGE_REF_W;
  localparam int ITEM_TARGET     = 1000;  // random references to send
  localparam int IDLE_LIMIT      = 2000;  // cycles without any transaction
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off
  localparam int LRU_HITS        = 12;    // repeats that push the other frames older
  localparam int TAIL_CYCLES     = 40;    // watch for stray results at the end
  localparam int IDLE_PCT        = 22;

  // Frame counts walked by the random phases; extremes and clamped values first.
  localparam logic [CFG_BITS-1:0] FRAMES_PLAN [10] =
    '{5'd16, 5'd1, 5'd31, 5'd2, 5'd17, 5'd0, 5'd8, 5'd3, 5'd12, 5'd5};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                                cfg_valid_i   = 1'b0;
  logic                                cfg_ready_o;
  logic [CFG_BITS-1:0]                 cfg_data_i    = '0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [lrupr_pkg::IN_TDATA_W-1:0]    s_axis_tdata  = '0;  // [15:0] page_ref
  logic                                s_axis_tlast  = 1'b0; // end_of_string
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [lrupr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
  // [3:0] frame_used, [19:4] evicted_page, [51:20] fault_total, [55:52] zero
  logic [lrupr_pkg::OUT_TUSER_W-1:0]   m_axis_tuser;  // [0] hit, [1] evicted

  int unsigned mismatches;
  int unsigned outstanding;

  // Shared between the sender and the receiver: steady_flow turns idling off,
  // sink_hold_req asks the receiver for one long hold-off.
  logic steady_flow   = 1'b0;
  logic sink_hold_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lru_page_replacement i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  lrupr_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .ref_valid_i   (s_axis_tvalid),
    .ref_ready_i   (s_axis_tready),
    .ref_page_i    (s_axis_tdata),
    .ref_last_i    (s_axis_tlast),
    .res_valid_i   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_data_i    (m_axis_tdata),
    .res_user_i    (m_axis_tuser),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // Offer one page reference and hold it until the transaction completes.
  // Leaves tvalid high; the caller drops it with stop_refs after a batch.
  task automatic send_ref(input logic [PAGE_W-1:0] pg, input logic eos);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pg;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic stop_refs();
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait until every expected result has come out; sample away from the edge.
  task automatic settle();
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  // Write frames_in_use, only once the block has drained.
  task automatic write_frames(input logic [CFG_BITS-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // One reference string drawn mostly from a small working set, so that hits,
  // fills and evictions all occur; a few pages are fully random noise. Most
  // strings end with end_of_string, a few run on into the next one.
  task automatic random_string(input int n_frames, inout int sent);
    logic [PAGE_W-1:0] pool[$];
    int                len;
    logic [PAGE_W-1:0] pg;
    logic              eos;
    repeat ($urandom_range(n_frames + 3, 1)) pool.push_back(PAGE_W'($urandom));
    len = $urandom_range(60, 4);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(99) < 10) pg = PAGE_W'($urandom);
      else pg = pool[$urandom_range(pool.size() - 1)];
      if (k == len - 1) eos = ($urandom_range(3) != 0);
      else eos = ($urandom_range(99) == 0);
      send_ref(pg, eos);
      sent++;
    end
  endtask

  // Receiver: random stalls, none while steady_flow is set, and one long
  // hold-off on request while the sender keeps offering references.
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run once no transaction has happened for too long.
  initial begin : watchdog
    int stalled_cycles;
    stalled_cycles = 0;
    wait (rst_ni === 1'b1);
    while (stalled_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        stalled_cycles = 0;
      else
        stalled_cycles++;
    end
    $display("[lru_page_replacement] ERROR");
    $finish;
  end

  initial begin : stimulus
    int                  random_items;
    int                  phase;
    int                  n_frames;
    logic [CFG_BITS-1:0] frames;
    random_items = 0;
    phase        = 0;

    // Hold reset low, then release it once.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default of four frames: fill with extreme pages, hit, evict the least
    // recently used, then end the string and check the table came back empty.
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'h8000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h8000, 1'b0);
    send_ref(16'h5555, 1'b0);
    send_ref(16'hAAAA, 1'b1);
    send_ref(16'hFFFF, 1'b1);
    stop_refs();

    // A frame count of zero acts as one frame.
    write_frames(5'd0);
    send_ref(16'h0005, 1'b0);
    send_ref(16'h0005, 1'b0);
    send_ref(16'h0006, 1'b1);
    stop_refs();

    // Frames outside the count keep their pages and ages: fill eight, shrink
    // to two, then grow back and hit the frames left alone meanwhile.
    write_frames(5'd8);
    for (int k = 0; k < 8; k++) send_ref(PAGE_W'(16'h0010 + k), 1'b0);
    stop_refs();
    write_frames(5'd2);
    send_ref(16'h0010, 1'b0);
    send_ref(16'h0099, 1'b0);
    send_ref(16'h0015, 1'b0);
    stop_refs();
    write_frames(5'd8);
    send_ref(16'h0015, 1'b0);
    send_ref(16'h0012, 1'b0);
    send_ref(16'h0016, 1'b1);
    stop_refs();

    // Recency order: make frame 0 younger than frame 1, then keep hitting
    // frame 2; the first miss must evict frame 1 and the next one frame 0.
    // Run this stretch with no idling on either side.
    write_frames(5'd3);
    send_ref(16'h00A0, 1'b0);
    send_ref(16'h00B0, 1'b0);
    send_ref(16'h00C0, 1'b0);
    send_ref(16'h00A0, 1'b0);
    steady_flow = 1'b1;
    repeat (LRU_HITS) send_ref(16'h00C0, 1'b0);
    send_ref(16'h00D0, 1'b0);
    send_ref(16'h00E0, 1'b1);
    steady_flow = 1'b0;
    stop_refs();

    // Random phases, one frame count each; values above the plan are random.
    while (random_items < ITEM_TARGET) begin
      if (phase < $size(FRAMES_PLAN)) frames = FRAMES_PLAN[phase];
      else frames = CFG_BITS'($urandom_range(31));
      write_frames(frames);
      if (frames == '0) n_frames = 1;
      else if (frames > 5'd16) n_frames = 16;
      else n_frames = int'(frames);
      // back up the result side once so that the input stalls
      if (phase == 2) sink_hold_req = 1'b1;
      if (phase == 6) steady_flow = 1'b1;
      random_string(n_frames, random_items);
      random_string(n_frames, random_items);
      steady_flow = 1'b0;
      stop_refs();
      phase++;
    end

    // Drain, then keep watching for results nobody asked for.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0)
      $display("[lru_page_replacement] OK");
    else
      $display("[lru_page_replacement] ERROR");
    $finish;
  end

endmodule

[files.f]
src/lrupr_pkg.sv
src/lrupr_ctrl.sv
src/lrupr_dp.sv
src/lru_page_replacement.sv
src/lrupr_chk.sv
tb/lrupr_checker.sv
tb/tb.sv
